FILE: rtl/sorted_priority_queue_unit_defines.svh
// ---------------------------------------------------------------------------
// sorted priority queue assertion macros
// shared property templates for the port-level checker
// ---------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// types and constants shared by the sorted priority queue modules
// ---------------------------------------------------------------------------
package spq_pkg;

  // number of cells in the chain
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // request action codes
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_PUSHED = 2'd0;
  localparam logic [1:0] ST_POPPED = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic               action;
    logic signed [31:0] priority_req;
    logic        [31:0] payload;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_payload;
    logic [4:0]  count;
  } spq_out_t;

  // contents of one cell
  typedef struct packed {
    logic               valid;
    logic signed [31:0] prio;
    logic        [31:0] payload;
  } spq_entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic               push;
    logic               pop;
    logic signed [31:0] prio;
    logic        [31:0] payload;
  } spq_cmd_t;

endpackage

FILE: rtl/sorted_priority_queue_unit.sv
// result: a request's result is registered and shown in the cycle after it is accepted
// throughput: one push or pop per cycle; busy is high only while reset is held
// every cell compares against the new priority in the same cycle, so the
// parallel compare and shift across the cell chain sets the rate
// reset: synchronous active-low rst_n empties the queue and clears the strobe
// ---------------------------------------------------------------------------
// sorted_priority_queue_unit
// min-first priority queue built as a chain of sorting cells; ties leave
// in arrival order
// ---------------------------------------------------------------------------
module sorted_priority_queue_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  spq_pkg::spq_in_t  in_req,
  output logic             out_valid,
  output spq_pkg::spq_out_t out_rsp
);
  import spq_pkg::*;

  logic                accept;
  logic                full, empty;
  spq_cmd_t            cmd;
  logic [CAPACITY-1:0] ins;
  spq_entry_t          entries [CAPACITY];

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_valid_r;
  spq_out_t            out_rsp_r, out_rsp_nxt;
  logic [CNT_W+4:0]    count_wide;

  // requests are held off only while reset is applied
  assign busy   = !rst_n;
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign empty  = (count_r == '0);

  // broadcast command
  always_comb begin
    cmd.push    = accept && (in_req.action == ACT_PUSH) && !full;
    cmd.pop     = accept && (in_req.action == ACT_POP) && !empty;
    cmd.prio    = in_req.priority_req;
    cmd.payload = in_req.payload;
  end

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic       l_ins;
    spq_entry_t l_entry, r_entry;
    if (i == 0) begin : g_head
      assign l_ins   = 1'b0;
      assign l_entry = '0;
    end else begin : g_mid
      assign l_ins   = ins[i-1];
      assign l_entry = entries[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign r_entry = '0;
    end else begin : g_body
      assign r_entry = entries[i+1];
    end
    spq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .left_ins    (l_ins),
      .left_entry  (l_entry),
      .right_entry (r_entry),
      .ins         (ins[i]),
      .entry       (entries[i])
    );
  end

  // count update and result build
  always_comb begin
    count_nxt               = count_r;
    out_rsp_nxt.out_payload = '0;
    if (in_req.action == ACT_PUSH) begin
      out_rsp_nxt.status = full ? ST_FULL : ST_PUSHED;
    end else begin
      out_rsp_nxt.status = empty ? ST_EMPTY : ST_POPPED;
    end
    if (cmd.push) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop) begin
      count_nxt               = count_r - 1'b1;
      out_rsp_nxt.out_payload = entries[0].payload;
    end
    count_wide        = {5'd0, count_nxt};
    out_rsp_nxt.count = count_wide[4:0];
  end

  // state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_rsp_r <= out_rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

FILE: rtl/spq_cell.sv
// ---------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds an entry, shifts right on insert
// and left on removal
// ---------------------------------------------------------------------------
module spq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::spq_cmd_t   cmd,
  input  logic               left_ins,
  input  spq_pkg::spq_entry_t left_entry,
  input  spq_pkg::spq_entry_t right_entry,
  output logic               ins,
  output spq_pkg::spq_entry_t entry
);
  import spq_pkg::*;

  logic               valid_r, valid_nxt;
  logic signed [31:0] prio_r, prio_nxt;
  logic        [31:0] payload_r, payload_nxt;

  // new entry belongs at or before this slot (strictly lower priority wins)
  assign ins = !valid_r || ($signed(cmd.prio) < $signed(prio_r));

  assign entry = '{valid: valid_r, prio: prio_r, payload: payload_r};

  // next contents
  always_comb begin
    valid_nxt   = valid_r;
    prio_nxt    = prio_r;
    payload_nxt = payload_r;
    if (cmd.push) begin
      if (left_ins) begin
        valid_nxt   = left_entry.valid;
        prio_nxt    = left_entry.prio;
        payload_nxt = left_entry.payload;
      end else if (ins) begin
        valid_nxt   = 1'b1;
        prio_nxt    = cmd.prio;
        payload_nxt = cmd.payload;
      end
    end else if (cmd.pop) begin
      valid_nxt   = right_entry.valid;
      prio_nxt    = right_entry.prio;
      payload_nxt = right_entry.payload;
    end
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // entry data
  always_ff @(posedge clk) begin
    prio_r    <= prio_nxt;
    payload_r <= payload_nxt;
  end

endmodule

FILE: rtl/spq_checker.sv
// ---------------------------------------------------------------------------
// spq_checker
// port-level checks for the sorted priority queue, bound to the top level
// ---------------------------------------------------------------------------
`include "sorted_priority_queue_unit_defines.svh"

module spq_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input spq_pkg::spq_out_t out_rsp
);
  import spq_pkg::*;

  // every accepted request yields exactly one result on the next cycle
  `SPQ_ASSERT_NEXT(a_rsp_follows, start && !busy, out_valid, "missing result")
  `SPQ_ASSERT_NEXT(a_no_spurious, !(start && !busy), !out_valid, "result without request")

  // payload only on a successful pop
  `SPQ_ASSERT_NOW(a_payload_zero, out_valid && (out_rsp.status != ST_POPPED),
                  out_rsp.out_payload == '0, "payload on non-pop result")

  // an empty pop reports a zero count
  `SPQ_ASSERT_NOW(a_empty_count, out_valid && (out_rsp.status == ST_EMPTY),
                  out_rsp.count == '0, "empty pop with nonzero count")

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (.*);

FILE: test/sorted_priority_queue_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sorted_priority_queue_unit_tb
// pushes and pops into the min-first queue and checks every result against
// a shadow copy of the sorted entry list; covers empty pops, full pushes,
// signed priority extremes and arrival order among equal priorities
// ---------------------------------------------------------------------------
module sorted_priority_queue_unit_tb;
  import spq_pkg::*;

  // one pending request plus how the driver should present it
  typedef struct packed {
    spq_in_t    req;
    logic [6:0] idle_pct;
    logic       drain;
  } pending_req_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  spq_in_t   in_req = '0;
  logic      out_valid;
  spq_out_t  out_rsp;

  pending_req_t req_pending_q[$];
  spq_out_t     expected_rsp_q[$];
  int unsigned  mismatch_count = 0;

  // shadow of the sorted entry list
  logic signed [31:0] shadow_prio [CAPACITY];
  logic        [31:0] shadow_data [CAPACITY];
  int unsigned        shadow_count = 0;

  // stimulus shaping state
  logic [6:0] cur_idle_pct = 7'd19;
  logic       drain_next = 1'b0;

  sorted_priority_queue_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // generous limit on the whole run
  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // apply one request to the shadow list and return the result it yields
  function automatic spq_out_t apply_queue_op(input spq_in_t req);
    spq_out_t    rsp;
    int unsigned pos;
    rsp = '0;
    if (req.action == ACT_PUSH) begin
      if (shadow_count >= CAPACITY) begin
        rsp.status = ST_FULL;
      end else begin
        // new entry lands before the first strictly higher priority
        pos = 0;
        while (pos < shadow_count &&
               !($signed(req.priority_req) < $signed(shadow_prio[pos])))
          pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_prio[i] = shadow_prio[i-1];
          shadow_data[i] = shadow_data[i-1];
        end
        shadow_prio[pos] = req.priority_req;
        shadow_data[pos] = req.payload;
        shadow_count++;
        rsp.status = ST_PUSHED;
      end
    end else begin
      if (shadow_count == 0) begin
        rsp.status = ST_EMPTY;
      end else begin
        rsp.out_payload = shadow_data[0];
        for (int i = 1; i < shadow_count; i++) begin
          shadow_prio[i-1] = shadow_prio[i];
          shadow_data[i-1] = shadow_data[i];
        end
        shadow_count--;
        rsp.status = ST_POPPED;
      end
    end
    rsp.count = 5'(shadow_count);
    return rsp;
  endfunction

  function automatic void add_req(input logic act, input logic [31:0] prio,
                                  input logic [31:0] data);
    pending_req_t item;
    item.req.action       = act;
    item.req.priority_req = prio;
    item.req.payload      = data;
    item.idle_pct         = cur_idle_pct;
    item.drain            = drain_next;
    drain_next            = 1'b0;
    req_pending_q.push_back(item);
  endfunction

  // mix of full-range, tie-prone small, near-extreme and whole Q16.16 values
  function automatic logic [31:0] pick_priority();
    logic [31:0] prio;
    case ($urandom_range(0, 3))
      0: prio = $urandom;
      1: prio = 32'($urandom_range(0, 7)) - 32'd4;
      2: prio = $urandom_range(0, 1) ? 32'h7fff_fffc + 32'($urandom_range(0, 3))
                                     : 32'h8000_0000 + 32'($urandom_range(0, 3));
      default: prio = (32'($urandom_range(0, 15)) - 32'd8) << 16;
    endcase
    return prio;
  endfunction

  // request driver: predicts on acceptance, then presents the next request
  always @(posedge clk) begin : req_driver
    logic accepted;
    accepted = rst_n && start && !busy;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (accepted) begin
        expected_rsp_q.push_back(apply_queue_op(in_req));
        void'(req_pending_q.pop_front());
      end
      if (!start || accepted) begin
        if (req_pending_q.size() != 0 &&
            !(req_pending_q[0].drain && expected_rsp_q.size() != 0) &&
            $urandom_range(0, 99) >= req_pending_q[0].idle_pct) begin
          start  <= 1'b1;
          in_req <= req_pending_q[0].req;
        end else begin
          start  <= 1'b0;
          in_req <= {1'($urandom_range(0, 1)), $urandom, $urandom};
        end
      end
    end
  end

  // result monitor: compare against the oldest expectation
  always @(posedge clk) begin : rsp_monitor
    spq_out_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_rsp_q.pop_front();
        if (out_rsp.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_rsp.status, want.status));
        if (out_rsp.out_payload !== want.out_payload)
          report_mismatch($sformatf("payload got %h want %h",
                                    out_rsp.out_payload, want.out_payload));
        if (out_rsp.count !== want.count)
          report_mismatch($sformatf("count got %0d want %0d",
                                    out_rsp.count, want.count));
      end
    end
  end

  initial begin : stimulus
    int unsigned n_rand;
    int unsigned burst_len;
    int unsigned pop_pct;

    // directed: pop on empty
    add_req(ACT_POP, 32'h1234_5678, 32'hdead_beef);
    // signed extremes and ties at zero
    add_req(ACT_PUSH, 32'h7fff_ffff, 32'hffff_ffff);
    add_req(ACT_PUSH, 32'h8000_0000, 32'h0000_0000);
    add_req(ACT_PUSH, 32'h0000_0000, 32'h0000_0001);
    add_req(ACT_PUSH, 32'hffff_ffff, 32'h0000_0002);
    add_req(ACT_PUSH, 32'h0000_0000, 32'h0000_0003);
    add_req(ACT_PUSH, 32'h0000_0000, 32'h0000_0004);
    // fill to capacity with more ties at both extremes
    add_req(ACT_PUSH, 32'h7fff_ffff, 32'h5555_5555);
    add_req(ACT_PUSH, 32'h8000_0000, 32'haaaa_aaaa);
    for (int i = 0; i < CAPACITY - 8; i++)
      add_req(ACT_PUSH, pick_priority(), $urandom);
    // push into a full queue is dropped
    add_req(ACT_PUSH, 32'h8000_0000, 32'hffff_ffff);
    for (int i = 0; i < 7; i++)
      add_req(ACT_POP, $urandom, $urandom);

    // random bursts that swing the queue between full and empty
    n_rand = 0;
    while (n_rand < 475) begin
      burst_len = $urandom_range(4, 40);
      case ($urandom_range(0, 2))
        0: pop_pct = 20;
        1: pop_pct = 80;
        default: pop_pct = 50;
      endcase
      for (int i = 0; i < burst_len; i++) begin
        // switch idle profile between phases, waiting for outstanding results first
        if (n_rand == 160) begin
          cur_idle_pct = 7'd64;
          drain_next   = 1'b1;
        end else if (n_rand == 320) begin
          cur_idle_pct = 7'd0;
          drain_next   = 1'b1;
        end else if ($urandom_range(0, 49) == 0) begin
          drain_next = 1'b1;
        end
        add_req(($urandom_range(0, 99) < pop_pct) ? ACT_POP : ACT_PUSH,
                pick_priority(), $urandom);
        n_rand++;
      end
    end

    // reset, then wait for all requests and results
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (req_pending_q.size() != 0 || expected_rsp_q.size() != 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
